[design/particle_integrate_and_fade_defines.svh]
// ----------------------------------------------------------------------------
// Particle integrate and fade: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is low.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_INTEGRATE_AND_FADE_DEFINES_SVH
`define PARTICLE_INTEGRATE_AND_FADE_DEFINES_SVH

// same-cycle implication
`define PIAF_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("piaf: invariant violated");

// next-cycle implication
`define PIAF_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("piaf: sequence violated");

`endif

[design/piaf_pkg.sv]
// ----------------------------------------------------------------------------
// Particle integrate and fade: package
// Widths, register indexes, operation codes and the command bundle shared
// by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package piaf_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int TIME_FRAC_BITS_DEF = 12;

    localparam int DT_W         = 12;
    localparam int LIFE_TOTAL_W = 16;
    localparam int LIFE_W       = 17;
    localparam int VEC_W        = 48;
    localparam int COMP_W       = 16;
    localparam int CH_W         = 8;
    localparam int RGBA_W       = 32;
    localparam int RGB_W        = 24;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam int S_TDATA_W = 16;
    localparam int OUT_BITS  = 129;
    localparam int M_TDATA_W = 136;

    localparam logic MODE_SPAWN = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_LIFE_TOTAL     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SPAWN_POSITION = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPAWN_VELOCITY = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCELERATION   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_BEGIN    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_FINAL    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_COLOR_BEGIN    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_COLOR_FINAL    = 3'd7;

    localparam int OP_W    = 4;
    localparam int NUM_OPS = 13;

    localparam logic [OP_W-1:0] OP_SCALE_X = 4'd0;
    localparam logic [OP_W-1:0] OP_SCALE_Y = 4'd1;
    localparam logic [OP_W-1:0] OP_SCALE_Z = 4'd2;
    localparam logic [OP_W-1:0] OP_RED     = 4'd3;
    localparam logic [OP_W-1:0] OP_GREEN   = 4'd4;
    localparam logic [OP_W-1:0] OP_BLUE    = 4'd5;
    localparam logic [OP_W-1:0] OP_ALPHA   = 4'd6;
    localparam logic [OP_W-1:0] OP_VEL_X   = 4'd7;
    localparam logic [OP_W-1:0] OP_VEL_Y   = 4'd8;
    localparam logic [OP_W-1:0] OP_VEL_Z   = 4'd9;
    localparam logic [OP_W-1:0] OP_POS_X   = 4'd10;
    localparam logic [OP_W-1:0] OP_POS_Y   = 4'd11;
    localparam logic [OP_W-1:0] OP_POS_Z   = 4'd12;

    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SCALE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COLOR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ALPHA = 3'd3;
    localparam logic [KIND_W-1:0] KIND_VEL   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POS   = 3'd5;

    typedef struct packed {
        logic            accept;
        logic            spawn;
        logic            div_step;
        logic            issue;
        logic [OP_W-1:0] op;
        logic            finish;
        logic            finish_step;
    } piaf_cmd_t;

    function automatic logic [KIND_W-1:0] op_kind(input logic [OP_W-1:0] op);
        logic [KIND_W-1:0] kind;
        unique case (op) inside
            OP_SCALE_X, OP_SCALE_Y, OP_SCALE_Z: kind = KIND_SCALE;
            OP_RED, OP_GREEN, OP_BLUE:          kind = KIND_COLOR;
            OP_ALPHA:                           kind = KIND_ALPHA;
            OP_VEL_X, OP_VEL_Y, OP_VEL_Z:       kind = KIND_VEL;
            OP_POS_X, OP_POS_Y, OP_POS_Z:       kind = KIND_POS;
            default:                            kind = KIND_NONE;
        endcase
        return kind;
    endfunction

    function automatic logic [1:0] op_index(input logic [OP_W-1:0] op);
        logic [1:0] idx;
        unique case (op) inside
            OP_SCALE_Y, OP_GREEN, OP_VEL_Y, OP_POS_Y: idx = 2'd1;
            OP_SCALE_Z, OP_BLUE, OP_VEL_Z, OP_POS_Z:  idx = 2'd2;
            default:                                  idx = 2'd0;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

[design/piaf_ctrl.sv]
// ----------------------------------------------------------------------------
// Particle integrate and fade: controller
// Sequences accept, life-fraction division, the shared multiply pass and
// the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_integrate_and_fade_defines.svh"

module piaf_ctrl
    import piaf_pkg::*;
#(
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    input  wire logic      s_tuser,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output piaf_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam int CNT_MAX = (TIME_FRAC_BITS > NUM_OPS) ? TIME_FRAC_BITS : NUM_OPS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TIME_FRAC_BITS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(NUM_OPS);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mode_reg, mode_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             accept;
    logic             slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.accept      = accept;
        cmd.spawn       = accept && (s_tuser == MODE_SPAWN);
        cmd.div_step    = (state_reg == ST_DIV);
        cmd.issue       = (state_reg == ST_MUL) && (cnt_reg < MUL_LAST);
        cmd.op          = cnt_reg[OP_W-1:0];
        cmd.finish      = (state_reg == ST_FIN) && slot_free;
        cmd.finish_step = (mode_reg == MODE_STEP);
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mode_next     = mode_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.finish) begin
            m_tvalid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next  = s_tuser;
                    cnt_next   = '0;
                    state_next = (s_tuser == MODE_SPAWN) ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL: begin
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            mode_reg     <= MODE_SPAWN;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `PIAF_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != ST_IDLE)
    `PIAF_ASSERT_NOW(a_finish_slot_free, aclk, aresetn, cmd.finish, !m_tvalid_reg || m_tready)
    `PIAF_ASSERT_NEXT(a_finish_shows_result, aclk, aresetn, cmd.finish, m_tvalid_reg)
    `PIAF_ASSERT_NOW(a_mul_count_bound, aclk, aresetn, state_reg == ST_MUL, cnt_reg <= MUL_LAST)

endmodule

`default_nettype wire

[design/piaf_datapath.sv]
// ----------------------------------------------------------------------------
// Particle integrate and fade: datapath
// Configuration registers, particle state, restoring divider for the life
// fraction, one shared multiplier with rounding write-back, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module piaf_datapath
    import piaf_pkg::*;
#(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [DT_W-1:0]       in_dt,
    input  wire piaf_cmd_t             cmd,
    output logic [M_TDATA_W-1:0]       m_tdata
);

    localparam int FW    = TIME_FRAC_BITS + 1;
    localparam int MA    = (COORD_BITS > COMP_W + 2) ? COORD_BITS : COMP_W + 2;
    localparam int MB    = (FW > DT_W) ? FW : DT_W;
    localparam int PW    = MA + MB + 1;
    localparam int SW    = PW + 1;
    localparam int EXT_W = (COORD_BITS > COMP_W) ? COORD_BITS : COMP_W;
    localparam int PAD_W = M_TDATA_W - OUT_BITS;

    localparam logic [FW-1:0] F_ONE = {1'b1, {TIME_FRAC_BITS{1'b0}}};
    localparam logic signed [SW-1:0] RND_HALF = SW'(64'sd1 <<< (TIME_FRAC_BITS - 1));
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (COORD_BITS - 1)));
    localparam logic signed [LIFE_W:0] LIFE_MIN = -18'sd65536;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic signed [COORD_BITS-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[COORD_BITS-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic [LIFE_TOTAL_W-1:0] life_total_reg;
    logic [VEC_W-1:0]        spawn_position_reg;
    logic [VEC_W-1:0]        spawn_velocity_reg;
    logic [VEC_W-1:0]        acceleration_reg;
    logic [VEC_W-1:0]        scale_begin_reg;
    logic [VEC_W-1:0]        scale_final_reg;
    logic [RGBA_W-1:0]       color_begin_reg;
    logic [RGB_W-1:0]        color_final_reg;

    logic signed [LIFE_W-1:0]     life_reg;
    logic [LIFE_TOTAL_W-1:0]      start_reg;
    logic signed [COORD_BITS-1:0] pos_reg [3];
    logic signed [COORD_BITS-1:0] vel_reg [3];

    logic [DT_W-1:0]           dt_reg;
    logic [LIFE_TOTAL_W-1:0]   rem_reg;
    logic [TIME_FRAC_BITS-1:0] q_reg;
    logic signed [PW-1:0]      prod_reg;
    logic                      wb_valid_reg;
    logic [OP_W-1:0]           wb_op_reg;
    logic [COMP_W-1:0]         size_reg [3];
    logic [CH_W-1:0]           color_reg [4];
    logic [M_TDATA_W-1:0]      m_tdata_reg;

    logic signed [LIFE_W-1:0]   life_diff;
    logic                       spec_one;
    logic                       spec_zero;
    logic [LIFE_TOTAL_W:0]      rem_sh;
    logic [LIFE_TOTAL_W:0]      rem_sub;
    logic                       rem_ge;
    logic [FW-1:0]              f_val;

    logic [KIND_W-1:0]          kind_i;
    logic [1:0]                 idx_i;
    logic signed [COMP_W:0]     lerp_a;
    logic signed [COMP_W:0]     lerp_b;
    logic signed [MA-1:0]       mul_a;
    logic [MB-1:0]              mul_b;
    logic signed [PW-1:0]       prod_next;

    logic [KIND_W-1:0]          kind_w;
    logic [1:0]                 idx_w;
    logic signed [SW-1:0]       rnd_w;
    logic signed [SW-1:0]       base_w;
    logic signed [SW-1:0]       sum_w;

    logic signed [LIFE_W:0]     life_dec;
    logic signed [LIFE_W-1:0]   life_new;
    logic                       alive;
    logic [COMP_W-1:0]          pos_out [3];
    logic [EXT_W-1:0]           pos_ext [3];

    // life fraction set-up and restoring division step
    assign life_diff = $signed({1'b0, start_reg}) - life_reg;
    assign spec_one  = (start_reg == '0) || (life_reg <= 0);
    assign spec_zero = (life_reg >= $signed({1'b0, start_reg}));
    assign rem_sh    = {rem_reg, 1'b0};
    assign rem_ge    = (rem_sh >= {1'b0, start_reg});
    assign rem_sub   = rem_sh - {1'b0, start_reg};
    assign f_val     = spec_one ? F_ONE : (spec_zero ? '0 : {1'b0, q_reg});

    // operand select for the issued operation
    always_comb begin
        kind_i = op_kind(cmd.op);
        idx_i  = op_index(cmd.op);
        lerp_a = '0;
        lerp_b = '0;
        case (kind_i)
            KIND_SCALE: begin
                lerp_a = (COMP_W + 1)'($signed(scale_begin_reg[{idx_i, 4'b0000} +: COMP_W]));
                lerp_b = (COMP_W + 1)'($signed(scale_final_reg[{idx_i, 4'b0000} +: COMP_W]));
            end
            KIND_COLOR: begin
                lerp_a = $signed({9'b0, color_begin_reg[5'd24 - {idx_i, 3'b000} +: CH_W]});
                lerp_b = $signed({9'b0, color_final_reg[5'd16 - {idx_i, 3'b000} +: CH_W]});
            end
            KIND_ALPHA: begin
                lerp_a = $signed({9'b0, color_begin_reg[CH_W-1:0]});
                lerp_b = '0;
            end
            default: ;
        endcase
        case (kind_i)
            KIND_VEL: begin
                mul_a = MA'($signed(acceleration_reg[{idx_i, 4'b0000} +: COMP_W]));
                mul_b = MB'(dt_reg);
            end
            KIND_POS: begin
                mul_a = MA'(vel_reg[idx_i]);
                mul_b = MB'(dt_reg);
            end
            default: begin
                mul_a = MA'(lerp_b) - MA'(lerp_a);
                mul_b = MB'(f_val);
            end
        endcase
        prod_next = mul_a * $signed({1'b0, mul_b});
    end

    // rounding write-back of the previous product
    always_comb begin
        kind_w = op_kind(wb_op_reg);
        idx_w  = op_index(wb_op_reg);
        rnd_w  = (SW'(prod_reg) + RND_HALF) >>> TIME_FRAC_BITS;
        case (kind_w)
            KIND_SCALE: base_w = SW'($signed(scale_begin_reg[{idx_w, 4'b0000} +: COMP_W]));
            KIND_COLOR: base_w = SW'($signed({1'b0,
                                     color_begin_reg[5'd24 - {idx_w, 3'b000} +: CH_W]}));
            KIND_ALPHA: base_w = SW'($signed({1'b0, color_begin_reg[CH_W-1:0]}));
            KIND_VEL:   base_w = SW'(vel_reg[idx_w]);
            KIND_POS:   base_w = SW'(pos_reg[idx_w]);
            default:    base_w = '0;
        endcase
        sum_w = base_w + rnd_w;
    end

    // life update and output formatting
    always_comb begin
        life_dec = (LIFE_W + 1)'(life_reg) - $signed({6'b0, dt_reg});
        if (life_dec < LIFE_MIN) begin
            life_new = LIFE_MIN[LIFE_W-1:0];
        end else begin
            life_new = life_dec[LIFE_W-1:0];
        end
        alive = cmd.finish_step ? !life_new[LIFE_W-1] : 1'b1;
        for (int k = 0; k < 3; k++) begin
            pos_ext[k] = EXT_W'(pos_reg[k]);
            pos_out[k] = pos_ext[k][COMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            life_total_reg     <= LIFE_TOTAL_W'(4096);
            spawn_position_reg <= '0;
            spawn_velocity_reg <= '0;
            acceleration_reg   <= '0;
            scale_begin_reg    <= '0;
            scale_final_reg    <= '0;
            color_begin_reg    <= '1;
            color_final_reg    <= '0;
            life_reg           <= '0;
            start_reg          <= '0;
            wb_valid_reg       <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                pos_reg[k] <= '0;
                vel_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_LIFE_TOTAL:     life_total_reg     <= cfg_wdata[LIFE_TOTAL_W-1:0];
                    REG_SPAWN_POSITION: spawn_position_reg <= cfg_wdata[VEC_W-1:0];
                    REG_SPAWN_VELOCITY: spawn_velocity_reg <= cfg_wdata[VEC_W-1:0];
                    REG_ACCELERATION:   acceleration_reg   <= cfg_wdata[VEC_W-1:0];
                    REG_SCALE_BEGIN:    scale_begin_reg    <= cfg_wdata[VEC_W-1:0];
                    REG_SCALE_FINAL:    scale_final_reg    <= cfg_wdata[VEC_W-1:0];
                    REG_COLOR_BEGIN:    color_begin_reg    <= cfg_wdata[RGBA_W-1:0];
                    REG_COLOR_FINAL:    color_final_reg    <= cfg_wdata[RGB_W-1:0];
                    default: ;
                endcase
            end
            wb_valid_reg <= cmd.issue;
            if (cmd.spawn) begin
                life_reg  <= $signed({1'b0, life_total_reg});
                start_reg <= life_total_reg;
                for (int k = 0; k < 3; k++) begin
                    pos_reg[k] <= sat_coord(SW'($signed(spawn_position_reg[16*k +: COMP_W])));
                    vel_reg[k] <= sat_coord(SW'($signed(spawn_velocity_reg[16*k +: COMP_W])));
                end
            end
            if (wb_valid_reg) begin
                case (kind_w)
                    KIND_VEL: vel_reg[idx_w] <= sat_coord(sum_w);
                    KIND_POS: pos_reg[idx_w] <= sat_coord(sum_w);
                    default: ;
                endcase
            end
            if (cmd.finish && cmd.finish_step) begin
                life_reg <= life_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            dt_reg  <= in_dt;
            rem_reg <= life_diff[LIFE_TOTAL_W-1:0];
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_sub[LIFE_TOTAL_W-1:0] : rem_sh[LIFE_TOTAL_W-1:0];
            q_reg   <= {q_reg[TIME_FRAC_BITS-2:0], rem_ge};
        end
        if (cmd.issue) begin
            prod_reg  <= prod_next;
            wb_op_reg <= cmd.op;
        end
        if (cmd.spawn) begin
            for (int k = 0; k < 3; k++) begin
                size_reg[k] <= scale_begin_reg[16*k +: COMP_W];
            end
            for (int k = 0; k < 4; k++) begin
                color_reg[k] <= color_begin_reg[24 - 8*k +: CH_W];
            end
        end
        if (wb_valid_reg) begin
            case (kind_w)
                KIND_SCALE: size_reg[idx_w]  <= sum_w[COMP_W-1:0];
                KIND_COLOR: color_reg[idx_w] <= sum_w[CH_W-1:0];
                KIND_ALPHA: color_reg[3]     <= sum_w[CH_W-1:0];
                default: ;
            endcase
        end
        if (cmd.finish) begin
            m_tdata_reg <= {PAD_W'(0), alive,
                            color_reg[3], color_reg[2], color_reg[1], color_reg[0],
                            size_reg[2], size_reg[1], size_reg[0],
                            pos_out[2], pos_out[1], pos_out[0]};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

`default_nettype wire

[design/particle_integrate_and_fade.sv]
// ----------------------------------------------------------------------------
// Particle integrate and fade
// One particle: spawn from configuration, or step by delta time with life
// fraction, scale and color lerp, and saturating Euler integration.
//
//   Channel  Direction  Payload
//   s_       in         tdata: delta_time; tuser: mode (0 spawn, 1 step)
//   m_       out        tdata: position, size, RGBA color, alive flag
//   cfg_     in         register index and write data, no read-back
//
// A spawn goes from accept straight to the finish state. A step runs the
// divider, one quotient bit a cycle, then 13 products on the shared
// multiplier with a registered write-back of each, then the finish state,
// which raises m_tvalid; the next accept waits until the block is idle.
// Reset is synchronous and clears state and control; no clearing pass.
// s_tready is high only while idle; the finish cycle waits for a held result.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_integrate_and_fade
    import piaf_pkg::*;
#(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // delta_time[11:0], zero pad
    input  wire logic                  s_tuser,  // mode

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata   // pos_x, pos_y, pos_z, size_x, size_y,
                                                 // size_z, red, green, blue, alpha,
                                                 // alive, zero pad
);

    piaf_cmd_t cmd;
    logic      unused_pad;

    assign unused_pad = ^s_tdata[S_TDATA_W-1:DT_W];

    piaf_ctrl #(
        .TIME_FRAC_BITS(TIME_FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    piaf_datapath #(
        .COORD_BITS    (COORD_BITS),
        .TIME_FRAC_BITS(TIME_FRAC_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .in_dt    (s_tdata[DT_W-1:0]),
        .cmd      (cmd),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[sim/particle_integrate_and_fade_test.sv]
// ----------------------------------------------------------------------------
// Particle integrate and fade: self-checking testbench
// Drives spawn and step transactions through the input stream, writes the
// configuration between phases while the block is idle, predicts each
// update (life fraction, scale and color lerp, saturating Euler step) and
// checks every result transaction in order. Phases vary sender idling and
// receiver stalls, and one phase holds the receiver off long enough to
// back the block up.
// ----------------------------------------------------------------------------

module particle_integrate_and_fade_test;
    import piaf_pkg::*;

    localparam int  QUIET_LIMIT = 4000;
    localparam int  LONG_HOLD   = 400;
    localparam int  SHOWN_MAX   = 10;
    localparam int  FRAC        = TIME_FRAC_BITS_DEF;
    localparam longint LIFE_FLOOR = -65536;
    localparam longint COORD_MAX  = (longint'(1) << (COORD_BITS_DEF - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;

    typedef struct packed {
        logic            mode;
        logic [DT_W-1:0] dt;
    } particle_cmd_t;

    // fields from the lowest bit up: pos_x .. pos_z, size_x .. size_z,
    // red, green, blue, alpha, alive
    typedef struct packed {
        logic                     alive;
        logic [CH_W-1:0]          alpha;
        logic [CH_W-1:0]          blue;
        logic [CH_W-1:0]          green;
        logic [CH_W-1:0]          red;
        logic signed [COMP_W-1:0] size_z;
        logic signed [COMP_W-1:0] size_y;
        logic signed [COMP_W-1:0] size_x;
        logic signed [COMP_W-1:0] pos_z;
        logic signed [COMP_W-1:0] pos_y;
        logic signed [COMP_W-1:0] pos_x;
    } particle_view_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // delta_time, zero pad
    logic                  s_tuser   = 1'b0; // mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // pos_x .. alive, zero pad

    particle_integrate_and_fade u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // register copies
    logic [LIFE_TOTAL_W-1:0] reg_life_total;
    logic [VEC_W-1:0]        reg_spawn_pos, reg_spawn_vel, reg_accel;
    logic [VEC_W-1:0]        reg_scale_begin, reg_scale_final;
    logic [RGBA_W-1:0]       reg_color_begin;
    logic [RGB_W-1:0]        reg_color_final;

    // particle state
    logic signed [LIFE_W-1:0]  life_left;
    logic [LIFE_TOTAL_W-1:0]   life_start;
    logic signed [COMP_W-1:0]  pos_now [3];
    logic signed [COMP_W-1:0]  vel_now [3];

    particle_cmd_t  pending_cmds [$];
    particle_view_t expected_updates [$];
    particle_cmd_t  offered;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_armed     = 1'b0;
    bit  hold_done      = 1'b0;
    int  hold_left      = 0;

    int  spawn_count, step_count, expired_count, checked_count, mismatch_count, phase_count;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- prediction ----------------

    function automatic longint comp16(logic [VEC_W-1:0] w, int k);
        return longint'($signed(w[COMP_W*k +: COMP_W]));
    endfunction

    function automatic longint round_q(longint v);
        return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic signed [COMP_W-1:0] clamp_coord(longint v);
        if (v > COORD_MAX) return COMP_W'(COORD_MAX);
        if (v < COORD_MIN) return COMP_W'(COORD_MIN);
        return v[COMP_W-1:0];
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        return a + round_q((b - a) * f);
    endfunction

    function automatic longint life_fraction();
        longint one, lv, sv;
        one = longint'(1) << FRAC;
        lv  = life_left;
        sv  = life_start;
        if (sv <= 0 || lv <= 0) return one;
        if (lv >= sv) return 0;
        return ((sv - lv) << FRAC) / sv;
    endfunction

    function automatic particle_view_t predict_update(particle_cmd_t cmd);
        particle_view_t v;
        longint f, step_dt, nl;
        v = '0;
        step_dt = longint'(cmd.dt);
        if (cmd.mode == MODE_SPAWN) begin
            life_left  = $signed({1'b0, reg_life_total});
            life_start = reg_life_total;
            for (int k = 0; k < 3; k++) begin
                pos_now[k] = clamp_coord(comp16(reg_spawn_pos, k));
                vel_now[k] = clamp_coord(comp16(reg_spawn_vel, k));
            end
            v.size_x = reg_scale_begin[15:0];
            v.size_y = reg_scale_begin[31:16];
            v.size_z = reg_scale_begin[47:32];
            v.red    = reg_color_begin[31:24];
            v.green  = reg_color_begin[23:16];
            v.blue   = reg_color_begin[15:8];
            v.alpha  = reg_color_begin[7:0];
            v.alive  = 1'b1;
            spawn_count++;
        end else begin
            f = life_fraction();
            v.size_x = COMP_W'(blend(comp16(reg_scale_begin, 0), comp16(reg_scale_final, 0), f));
            v.size_y = COMP_W'(blend(comp16(reg_scale_begin, 1), comp16(reg_scale_final, 1), f));
            v.size_z = COMP_W'(blend(comp16(reg_scale_begin, 2), comp16(reg_scale_final, 2), f));
            v.red    = CH_W'(blend(reg_color_begin[31:24], reg_color_final[23:16], f));
            v.green  = CH_W'(blend(reg_color_begin[23:16], reg_color_final[15:8], f));
            v.blue   = CH_W'(blend(reg_color_begin[15:8], reg_color_final[7:0], f));
            v.alpha  = CH_W'(blend(reg_color_begin[7:0], 0, f));
            for (int k = 0; k < 3; k++) begin
                vel_now[k] = clamp_coord(longint'(vel_now[k]) +
                                         round_q(comp16(reg_accel, k) * step_dt));
                pos_now[k] = clamp_coord(longint'(pos_now[k]) +
                                         round_q(longint'(vel_now[k]) * step_dt));
            end
            nl = longint'(life_left) - step_dt;
            if (nl < LIFE_FLOOR) nl = LIFE_FLOOR;
            life_left = nl[LIFE_W-1:0];
            v.alive   = (life_left >= 0);
            step_count++;
            if (!v.alive) expired_count++;
        end
        v.pos_x = pos_now[0];
        v.pos_y = pos_now[1];
        v.pos_z = pos_now[2];
        return v;
    endfunction

    function automatic string show(particle_view_t v);
        return $sformatf("pos %0d %0d %0d size %0d %0d %0d rgba %0d %0d %0d %0d alive %0d",
                         v.pos_x, v.pos_y, v.pos_z, v.size_x, v.size_y, v.size_z,
                         v.red, v.green, v.blue, v.alpha, v.alive);
    endfunction

    // ---------------- driver, receiver, monitor ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_updates.push_back(predict_update(offered));
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered  = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(offered.dt);
                    s_tuser  <= offered.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        particle_view_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_BITS-1:0];
            checked_count++;
            if (expected_updates.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_MAX)
                    $display("result %0d with no transaction pending: %s",
                             checked_count, show(got));
            end else begin
                want = expected_updates.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MAX) begin
                        $display("result %0d differs", checked_count);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------- stimulus ----------------

    task automatic queue_cmd(logic mode, int dt);
        particle_cmd_t c;
        c.mode = mode;
        c.dt   = DT_W'(dt);
        pending_cmds.push_back(c);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_LIFE_TOTAL:     reg_life_total  = val[LIFE_TOTAL_W-1:0];
            REG_SPAWN_POSITION: reg_spawn_pos   = val;
            REG_SPAWN_VELOCITY: reg_spawn_vel   = val;
            REG_ACCELERATION:   reg_accel       = val;
            REG_SCALE_BEGIN:    reg_scale_begin = val;
            REG_SCALE_FINAL:    reg_scale_final = val;
            REG_COLOR_BEGIN:    reg_color_begin = val[RGBA_W-1:0];
            REG_COLOR_FINAL:    reg_color_final = val[RGB_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_updates.size() != 0);
    endtask

    function automatic logic [VEC_W-1:0] rand_vec();
        logic [VEC_W-1:0] w;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
                0:       w[COMP_W*k +: COMP_W] = 16'h7FFF;
                1:       w[COMP_W*k +: COMP_W] = 16'h8000;
                2, 3:    w[COMP_W*k +: COMP_W] = 16'($urandom_range(0, 1023) - 512);
                default: w[COMP_W*k +: COMP_W] = 16'($urandom);
            endcase
        end
        return w;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_life();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'(16'hFFFF);
            2:       return CFG_DATA_W'($urandom_range(1, 16));
            default: return CFG_DATA_W'($urandom_range(256, 12288));
        endcase
    endfunction

    function automatic int pick_dt();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 4095;
            2, 3:    return $urandom_range(0, 4095);
            default: return $urandom_range(1, 1200);
        endcase
    endfunction

    task automatic write_random_config(bit every);
        if (every || $urandom_range(0, 1)) write_reg(REG_LIFE_TOTAL, rand_life());
        if (every || $urandom_range(0, 1)) write_reg(REG_SPAWN_POSITION, rand_vec());
        if (every || $urandom_range(0, 1)) write_reg(REG_SPAWN_VELOCITY, rand_vec());
        if (every || $urandom_range(0, 1)) write_reg(REG_ACCELERATION, rand_vec());
        if (every || $urandom_range(0, 1)) write_reg(REG_SCALE_BEGIN, rand_vec());
        if (every || $urandom_range(0, 1)) write_reg(REG_SCALE_FINAL, rand_vec());
        if (every || $urandom_range(0, 1))
            write_reg(REG_COLOR_BEGIN, CFG_DATA_W'({$urandom, $urandom}));
        if (every || $urandom_range(0, 1))
            write_reg(REG_COLOR_FINAL, CFG_DATA_W'({$urandom, $urandom}));
        end_writes();
    endtask

    task automatic queue_random(int count);
        int n, run;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 85) begin
                queue_cmd(MODE_SPAWN, $urandom_range(0, 4095));
                run = $urandom_range(1, 12);
                repeat (run) queue_cmd(MODE_STEP, pick_dt());
                n += run + 1;
            end else begin
                queue_cmd($urandom_range(0, 1) ? MODE_STEP : MODE_SPAWN, $urandom_range(0, 4095));
                n++;
            end
        end
    endtask

    initial begin
        reg_life_total  = 16'd4096;
        reg_spawn_pos   = '0;
        reg_spawn_vel   = '0;
        reg_accel       = '0;
        reg_scale_begin = '0;
        reg_scale_final = '0;
        reg_color_begin = 32'hFFFF_FFFF;
        reg_color_final = '0;
        life_left       = '0;
        life_start      = '0;
        for (int k = 0; k < 3; k++) begin
            pos_now[k] = '0;
            vel_now[k] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: step before any spawn, then a full short life
        queue_cmd(MODE_STEP, 0);
        queue_cmd(MODE_STEP, 4095);
        queue_cmd(MODE_SPAWN, 0);
        queue_cmd(MODE_STEP, 0);
        queue_cmd(MODE_STEP, 1);
        queue_cmd(MODE_STEP, 4094);
        queue_cmd(MODE_STEP, 1);
        wait_drained();

        // high extremes, saturation upward
        write_reg(REG_LIFE_TOTAL, 48'hFFFF);
        write_reg(REG_SPAWN_POSITION, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_SPAWN_VELOCITY, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_ACCELERATION, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_SCALE_BEGIN, 48'h8000_8000_8000);
        write_reg(REG_SCALE_FINAL, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_COLOR_BEGIN, 48'h0);
        write_reg(REG_COLOR_FINAL, 48'hFF_FFFF);
        end_writes();
        queue_cmd(MODE_SPAWN, 4095);
        queue_cmd(MODE_STEP, 4095);
        queue_cmd(MODE_STEP, 4095);
        queue_cmd(MODE_STEP, 0);
        wait_drained();

        // change acceleration and colors mid-life, no respawn
        write_reg(REG_ACCELERATION, 48'h8000_8000_8000);
        write_reg(REG_COLOR_BEGIN, 48'hFFFF_FFFF);
        write_reg(REG_COLOR_FINAL, 48'h0);
        end_writes();
        queue_cmd(MODE_STEP, 4095);
        queue_cmd(MODE_STEP, 4095);
        wait_drained();

        // low extremes, zero lifetime, saturation downward
        write_reg(REG_LIFE_TOTAL, 48'h0);
        write_reg(REG_SPAWN_POSITION, 48'h8000_8000_8000);
        write_reg(REG_SPAWN_VELOCITY, 48'h8000_8000_8000);
        write_reg(REG_SCALE_BEGIN, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_SCALE_FINAL, 48'h8000_8000_8000);
        end_writes();
        queue_cmd(MODE_SPAWN, 0);
        queue_cmd(MODE_STEP, 4095);
        queue_cmd(MODE_STEP, 2048);
        wait_drained();
        phase_count = 4;

        for (int p = 0; p < 8; p++) begin
            write_random_config(p == 0);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p == 4) hold_armed = 1'b1;
            queue_random(85);
            wait_drained();
            phase_count++;
        end

        repeat (64) @(negedge aclk);
        mismatch_count += expected_updates.size();
        $display("covered %0d spawns and %0d steps (%0d past end of life) over %0d phases",
                 spawn_count, step_count, expired_count, phase_count);
        $display("checked %0d results, %0d mismatches", checked_count, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
